// File: src/sawarq_pkg.sv
// Shared types and constants for the stop-and-wait ARQ sender.
`timescale 1ns / 1ps

package sawarq_pkg;

    typedef enum logic [1:0] {
        PH_LOAD = 2'd0,
        PH_SEND = 2'd1,
        PH_WAIT = 2'd2,
        PH_FAIL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_PULL = 2'd1,
        CMD_ACK  = 2'd2,
        CMD_TICK = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_ATTEMPT_LIMIT = 1'b0,
        REG_TIMEOUT_TICKS = 1'b1
    } reg_idx_t;

    localparam logic [7:0]  FRAME_TYPE    = 8'd0;
    localparam logic [7:0]  ACK_TYPE      = 8'd1;
    localparam logic [6:0]  MIN_ACK_LEN   = 7'd3;
    localparam int          HDR_LEN       = 4;
    localparam logic [3:0]  ATTEMPT_RST   = 4'd10;
    localparam logic [15:0] TIMEOUT_RST   = 16'd2000;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
        phase_t     phase;
        logic       chunk_acked;
        logic [3:0] attempt_count;
        logic       current_seq;
        logic       item_ignored;
        logic       use_mem;
    } result_t;

endpackage

// File: src/sawarq_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module sawarq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/stop_and_wait_arq_sender_unit.sv
// Stop-and-wait ARQ sender: frame store, framing, ack check, retry control.
// Path: a result is registered in stage 1, then in the output register; back-pressure can hold either.
// Throughput: one word per cycle while the output is taken; a word writes or reads the frame store at most once.
// A finished result waits in the output register while the next word is taken.
// Reset: async active low; sequence 0, loading, counters cleared, limit 10, timeout 2000.
// The frame store is not cleared; only bytes written for the current chunk are read.
`timescale 1ns / 1ps

module stop_and_wait_arq_sender_unit
    import sawarq_pkg::*;
#(
    parameter int MAX_CHUNK = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte, ack_length, ack_type, ack_seq, ack_check
    input  logic [1:0]  s_tuser,   // cmd
    input  logic        s_tlast,   // data_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // tx_byte, phase, chunk_acked, attempt_count,
                                   // current_seq, item_ignored
    output logic        m_tuser,   // tx_valid
    output logic        m_tlast    // tx_last
);

    localparam int ADDR_W = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
    localparam int CNT_W  = $clog2(MAX_CHUNK + 1);
    localparam int IDX_W  = $clog2(MAX_CHUNK + HDR_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHUNK);
    localparam logic [IDX_W-1:0] IDX_TYPE = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_SEQ  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LHI  = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_LLO  = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_HDR  = IDX_W'(HDR_LEN);

    // input fields
    cmd_t       in_cmd;
    logic [7:0] in_byte;
    logic [6:0] in_alen;
    logic [7:0] in_atype;
    logic [7:0] in_aseq;
    logic [7:0] in_acheck;

    assign in_cmd    = cmd_t'(s_tuser);
    assign in_byte   = s_tdata[7:0];
    assign in_alen   = s_tdata[14:8];
    assign in_atype  = s_tdata[22:15];
    assign in_aseq   = s_tdata[30:23];
    assign in_acheck = s_tdata[38:31];

    // configuration
    logic [3:0]  attempt_limit_reg;
    logic [15:0] timeout_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_limit_reg <= ATTEMPT_RST;
            timeout_ticks_reg <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_ATTEMPT_LIMIT: attempt_limit_reg <= cfg_wdata[3:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata;
                default:           attempt_limit_reg <= attempt_limit_reg;
            endcase
        end
    end

    // sender state
    phase_t           phase_reg,    phase_next;
    logic             seq_reg,      seq_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic [7:0]       sum_reg,      sum_next;
    logic [IDX_W-1:0] tx_index_reg, tx_index_next;
    logic [3:0]       attempts_reg, attempts_next;
    logic [15:0]      timer_reg,    timer_next;

    // pipeline
    logic    s1_valid_reg, s1_valid_next;
    result_t s1_reg,       s1_next;
    logic    m_valid_reg,  m_valid_next;
    result_t m_reg,        m_next;

    logic             accept;
    logic             s1_move;
    logic             mem_we;
    logic             mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;
    logic [15:0]      payload_len;
    logic [CNT_W-1:0] count_inc;
    logic [15:0]      timer_inc;
    logic             ack_ok;

    assign s1_move  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    assign payload_len = 16'(count_reg);
    assign count_inc = count_reg + CNT_W'(1);
    assign timer_inc = (timer_reg < TIMER_MAX) ? timer_reg + 16'd1 : timer_reg;
    assign ack_ok    = (in_alen >= MIN_ACK_LEN) && (in_atype == ACK_TYPE)
                    && (in_acheck == 8'(in_atype + in_aseq))
                    && (in_aseq == {7'd0, seq_reg});
    assign mem_raddr = ADDR_W'(tx_index_reg - IDX_HDR);

    sawarq_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHUNK)
    ) u_frame_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(count_reg)),
        .wdata (in_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LOAD;
            seq_reg      <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            tx_index_reg <= '0;
            attempts_reg <= '0;
            timer_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            seq_reg      <= seq_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            tx_index_reg <= tx_index_next;
            attempts_reg <= attempts_next;
            timer_reg    <= timer_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        m_reg  <= m_next;
    end

    // item processing
    always_comb
    begin
        phase_next    = phase_reg;
        seq_next      = seq_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        tx_index_next = tx_index_reg;
        attempts_next = attempts_reg;
        timer_next    = timer_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        s1_next       = s1_reg;
        s1_next.tx_valid     = 1'b0;
        s1_next.tx_byte      = 8'd0;
        s1_next.tx_last      = 1'b0;
        s1_next.chunk_acked  = 1'b0;
        s1_next.item_ignored = 1'b0;
        s1_next.use_mem      = 1'b0;

        if (accept)
        begin
            priority if (in_cmd == CMD_LOAD && phase_reg == PH_LOAD)
            begin
                if (count_reg < CNT_MAX)
                begin
                    mem_we     = 1'b1;
                    count_next = count_inc;
                    sum_next   = sum_reg + in_byte;
                end
                if (s_tlast || count_next >= CNT_MAX)
                begin
                    attempts_next = 4'd1;
                    phase_next    = PH_SEND;
                    tx_index_next = '0;
                end
            end
            else if (in_cmd == CMD_PULL && phase_reg == PH_SEND)
            begin
                s1_next.tx_valid = 1'b1;
                tx_index_next    = tx_index_reg + IDX_W'(1);
                priority if (tx_index_reg == IDX_TYPE)
                    s1_next.tx_byte = FRAME_TYPE;
                else if (tx_index_reg == IDX_SEQ)
                    s1_next.tx_byte = {7'd0, seq_reg};
                else if (tx_index_reg == IDX_LHI)
                    s1_next.tx_byte = payload_len[15:8];
                else if (tx_index_reg == IDX_LLO)
                    s1_next.tx_byte = payload_len[7:0];
                else if (tx_index_reg < IDX_W'(count_reg) + IDX_HDR)
                begin
                    mem_re          = 1'b1;
                    s1_next.use_mem = 1'b1;
                end
                else
                begin
                    s1_next.tx_byte = 8'({7'd0, seq_reg} + payload_len[15:8]
                                         + payload_len[7:0] + sum_reg);
                    s1_next.tx_last = 1'b1;
                    phase_next      = PH_WAIT;
                    timer_next      = '0;
                    tx_index_next   = '0;
                end
            end
            else if (in_cmd == CMD_ACK && phase_reg == PH_WAIT)
            begin
                if (ack_ok)
                begin
                    s1_next.chunk_acked = 1'b1;
                    seq_next      = !seq_reg;
                    phase_next    = PH_LOAD;
                    count_next    = '0;
                    sum_next      = '0;
                    tx_index_next = '0;
                end
                else if (attempts_reg >= attempt_limit_reg)
                    phase_next = PH_FAIL;
                else
                begin
                    attempts_next = attempts_reg + 4'd1;
                    phase_next    = PH_SEND;
                    tx_index_next = '0;
                end
            end
            else if (in_cmd == CMD_TICK && phase_reg == PH_WAIT)
            begin
                timer_next = timer_inc;
                if (timer_inc >= timeout_ticks_reg)
                begin
                    if (attempts_reg >= attempt_limit_reg)
                        phase_next = PH_FAIL;
                    else
                    begin
                        attempts_next = attempts_reg + 4'd1;
                        phase_next    = PH_SEND;
                        tx_index_next = '0;
                    end
                end
            end
            else
                s1_next.item_ignored = 1'b1;

            s1_next.phase         = phase_next;
            s1_next.attempt_count = attempts_next;
            s1_next.current_seq   = seq_next;
        end
        else
            s1_next = s1_reg;
    end

    // pipeline advance
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        m_valid_next  = m_valid_reg;
        m_next        = m_reg;
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;
        if (s1_valid_reg && s1_move)
        begin
            m_valid_next = 1'b1;
            m_next       = s1_reg;
            if (s1_reg.use_mem)
                m_next.tx_byte = mem_rdata;
            s1_valid_next = 1'b0;
        end
        if (accept)
            s1_valid_next = 1'b1;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_reg.tx_valid;
    assign m_tlast  = m_reg.tx_last;
    assign m_tdata  = {7'd0, m_reg.item_ignored, m_reg.current_seq, m_reg.attempt_count,
                       m_reg.chunk_acked, m_reg.phase, m_reg.tx_byte};

    // checks
    a_fail_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAIL |=> phase_reg == PH_FAIL)
        else $error("failed phase left");

    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SEND |-> tx_index_reg <= IDX_W'(count_reg) + IDX_HDR)
        else $error("tx index beyond frame");

    a_last_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_reg.tx_last |-> m_reg.phase == PH_WAIT && m_reg.tx_valid)
        else $error("frame end without wait");

    a_ack_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.chunk_acked |-> s1_reg.phase == PH_LOAD
            && !s1_reg.item_ignored && !s1_reg.tx_valid)
        else $error("ack result inconsistent");

    a_mem_read_in_send: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> phase_reg == PH_SEND && !mem_we)
        else $error("frame store read outside sending");

endmodule

// File: test/stop_and_wait_arq_sender_unit_tb.sv
// Self-checking testbench for the stop-and-wait ARQ sender: directed and random words.
`timescale 1ns / 1ps

import sawarq_pkg::*;

typedef struct {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       data_last;
    logic [6:0] ack_length;
    logic [7:0] ack_type;
    logic [7:0] ack_seq;
    logic [7:0] ack_check;
} arq_word_t;

typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [1:0] phase;
    logic       chunk_acked;
    logic [3:0] attempt_count;
    logic       current_seq;
    logic       item_ignored;
} tx_result_t;

// Tracks sender state and holds the expected output word for every accepted input word.
class arq_sender_tracker;
    localparam int CHUNK_MAX = 512;

    logic [3:0]  attempt_limit;
    logic [15:0] timeout_ticks;
    logic        seq_bit;
    phase_t      phase;
    logic [7:0]  store [0:CHUNK_MAX-1];
    logic [9:0]  payload_count;
    logic [7:0]  data_sum;
    logic [9:0]  tx_index;
    logic [3:0]  attempts;
    logic [15:0] wait_timer;

    tx_result_t  expected_tx[$];
    int          failures;
    int          results_seen;

    function new();
        attempt_limit = ATTEMPT_RST;
        timeout_ticks = TIMEOUT_RST;
        seq_bit       = 1'b0;
        phase         = PH_LOAD;
        payload_count = '0;
        data_sum      = '0;
        tx_index      = '0;
        attempts      = '0;
        wait_timer    = '0;
        failures      = 0;
        results_seen  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] value);
        case (idx)
            REG_ATTEMPT_LIMIT: attempt_limit = value[3:0];
            REG_TIMEOUT_TICKS: timeout_ticks = value;
            default: ;
        endcase
    endfunction

    function void resend_or_give_up();
        if (attempts >= attempt_limit)
        begin
            phase = PH_FAIL;
        end
        else
        begin
            attempts = attempts + 4'd1;
            phase    = PH_SEND;
            tx_index = '0;
        end
    endfunction

    // Returns 1 when the word has no effect in the current phase.
    function bit take_word(arq_word_t w);
        tx_result_t r;
        logic [7:0] len_hi;
        logic [7:0] len_lo;
        bit         ack_ok;
        r      = '0;
        len_hi = {6'd0, payload_count[9:8]};
        len_lo = payload_count[7:0];
        if (w.cmd == CMD_LOAD && phase == PH_LOAD)
        begin
            if (payload_count < CHUNK_MAX)
            begin
                store[payload_count] = w.data_byte;
                payload_count        = payload_count + 10'd1;
                data_sum             = data_sum + w.data_byte;
            end
            if (w.data_last || payload_count >= CHUNK_MAX)
            begin
                attempts = 4'd1;
                phase    = PH_SEND;
                tx_index = '0;
            end
        end
        else if (w.cmd == CMD_PULL && phase == PH_SEND)
        begin
            r.tx_valid = 1'b1;
            if (tx_index == 0)
                r.tx_byte = FRAME_TYPE;
            else if (tx_index == 1)
                r.tx_byte = {7'd0, seq_bit};
            else if (tx_index == 2)
                r.tx_byte = len_hi;
            else if (tx_index == 3)
                r.tx_byte = len_lo;
            else if (tx_index - HDR_LEN < payload_count)
                r.tx_byte = store[tx_index - HDR_LEN];
            else
            begin
                r.tx_byte = {7'd0, seq_bit} + len_hi + len_lo + data_sum;
                r.tx_last = 1'b1;
            end
            if (r.tx_last)
            begin
                phase      = PH_WAIT;
                wait_timer = '0;
                tx_index   = '0;
            end
            else
                tx_index = tx_index + 10'd1;
        end
        else if (w.cmd == CMD_ACK && phase == PH_WAIT)
        begin
            ack_ok = w.ack_length >= MIN_ACK_LEN && w.ack_type == ACK_TYPE &&
                     w.ack_check == w.ack_type + w.ack_seq && w.ack_seq == {7'd0, seq_bit};
            if (ack_ok)
            begin
                r.chunk_acked = 1'b1;
                seq_bit       = ~seq_bit;
                phase         = PH_LOAD;
                payload_count = '0;
                data_sum      = '0;
                tx_index      = '0;
            end
            else
                resend_or_give_up();
        end
        else if (w.cmd == CMD_TICK && phase == PH_WAIT)
        begin
            if (wait_timer != TIMER_MAX)
                wait_timer = wait_timer + 16'd1;
            if (wait_timer >= timeout_ticks)
                resend_or_give_up();
        end
        else
            r.item_ignored = 1'b1;
        r.phase         = phase;
        r.attempt_count = attempts;
        r.current_seq   = seq_bit;
        expected_tx.push_back(r);
        return r.item_ignored;
    endfunction

    function void check_tx(tx_result_t got);
        tx_result_t want;
        results_seen++;
        if (expected_tx.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("unexpected output word %0d: byte=%02h phase=%0d", results_seen,
                         got.tx_byte, got.phase);
            return;
        end
        want = expected_tx.pop_front();
        if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
            got.tx_last !== want.tx_last || got.phase !== want.phase ||
            got.chunk_acked !== want.chunk_acked || got.attempt_count !== want.attempt_count ||
            got.current_seq !== want.current_seq || got.item_ignored !== want.item_ignored)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("word %0d expected: v=%0d byte=%02h last=%0d ph=%0d ack=%0d att=%0d seq=%0d ign=%0d",
                         results_seen, want.tx_valid, want.tx_byte, want.tx_last, want.phase,
                         want.chunk_acked, want.attempt_count, want.current_seq,
                         want.item_ignored);
                $display("word %0d actual:   v=%0d byte=%02h last=%0d ph=%0d ack=%0d att=%0d seq=%0d ign=%0d",
                         results_seen, got.tx_valid, got.tx_byte, got.tx_last, got.phase,
                         got.chunk_acked, got.attempt_count, got.current_seq, got.item_ignored);
            end
        end
    endfunction

    function int pending();
        return expected_tx.size();
    endfunction
endclass

module stop_and_wait_arq_sender_unit_tb;

    localparam int CHUNK_MAX = 512;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // data_byte, ack_length, ack_type, ack_seq, ack_check
    logic [1:0]  s_tuser   = '0;   // cmd
    logic        s_tlast   = 1'b0; // data_last
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // tx_byte, phase, chunk_acked, attempt_count,
                                   // current_seq, item_ignored
    logic        m_tuser;          // tx_valid
    logic        m_tlast;          // tx_last

    arq_sender_tracker model = new();
    int                words_sent   = 0;
    bit                last_ignored = 1'b0;
    bit                tvalid_held  = 1'b0;

    stop_and_wait_arq_sender_unit #(.MAX_CHUNK(CHUNK_MAX)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int sender_gap();
        int r;
        if ((words_sent / 200) % 4 == 2)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic arq_word_t noise_word(cmd_t c);
        arq_word_t w;
        w.cmd        = c;
        w.data_byte  = 8'($urandom_range(0, 255));
        w.data_last  = 1'($urandom_range(0, 1));
        w.ack_length = 7'($urandom_range(0, 64));
        w.ack_type   = 8'($urandom_range(0, 255));
        w.ack_seq    = 8'($urandom_range(0, 255));
        w.ack_check  = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic arq_word_t mk(cmd_t c, logic [7:0] b, logic l, logic [6:0] len,
                                     logic [7:0] t, logic [7:0] s, logic [7:0] k);
        arq_word_t w;
        w.cmd        = c;
        w.data_byte  = b;
        w.data_last  = l;
        w.ack_length = len;
        w.ack_type   = t;
        w.ack_seq    = s;
        w.ack_check  = k;
        return w;
    endfunction

    // Word for the waiting phase; keeps the sender out of the failed phase unless allowed.
    function automatic arq_word_t wait_word(int ok_pct, bit may_fail);
        arq_word_t   w;
        int          r;
        int          kind;
        bit          risky;
        logic [15:0] next_timer;
        logic [7:0]  delta;
        w          = noise_word(CMD_ACK);
        r          = $urandom_range(0, 99);
        risky      = !may_fail && (model.attempts >= model.attempt_limit);
        next_timer = (model.wait_timer == TIMER_MAX) ? TIMER_MAX : model.wait_timer + 16'd1;
        if (r < 5)
        begin
            w.cmd = ($urandom_range(0, 1) != 0) ? CMD_LOAD : CMD_PULL;
            return w;
        end
        if (r < 5 + ok_pct)
            kind = 0;
        else if (r < 5 + ok_pct + (95 - ok_pct) / 2)
            kind = 1;
        else
            kind = 2;
        if (risky && (kind == 2 || (kind == 1 && next_timer >= model.timeout_ticks)))
            kind = 0;
        if (kind == 1)
        begin
            w.cmd = CMD_TICK;
            return w;
        end
        w.ack_length = 7'($urandom_range(3, 64));
        w.ack_type   = ACK_TYPE;
        w.ack_seq    = {7'd0, model.seq_bit};
        w.ack_check  = w.ack_type + w.ack_seq;
        if (kind == 2)
        begin
            case ($urandom_range(0, 4))
                0: w.ack_length = 7'($urandom_range(0, 2));
                1:
                begin
                    w.ack_type = 8'($urandom_range(0, 255));
                    if (w.ack_type == ACK_TYPE)
                        w.ack_type = 8'd2;
                    w.ack_check = w.ack_type + w.ack_seq;
                end
                2:
                begin
                    delta       = 8'($urandom_range(1, 255));
                    w.ack_check = w.ack_check + delta;
                end
                3:
                begin
                    w.ack_seq = 8'($urandom_range(0, 255));
                    if (w.ack_seq == {7'd0, model.seq_bit})
                        w.ack_seq = w.ack_seq ^ 8'd1;
                    w.ack_check = ACK_TYPE + w.ack_seq;
                end
                default: w = noise_word(CMD_ACK);
            endcase
        end
        return w;
    endfunction

    task automatic send_word(input arq_word_t w);
        int gap;
        s_tvalid    <= 1'b1;
        s_tdata     <= {1'b0, w.ack_check, w.ack_seq, w.ack_type, w.ack_length, w.data_byte};
        s_tuser     <= w.cmd;
        s_tlast     <= w.data_last;
        tvalid_held = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        last_ignored = model.take_word(w);
        words_sent++;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid    <= 1'b0;
            tvalid_held = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        if (tvalid_held)
        begin
            s_tvalid    <= 1'b0;
            tvalid_held = 1'b0;
        end
        while (model.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        model.set_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int n_items, input int ok_pct, input bit may_fail);
        int        counted;
        cmd_t      c;
        arq_word_t w;
        counted = 0;
        while (counted < n_items && model.phase != PH_FAIL)
        begin
            case (model.phase)
                PH_LOAD:
                begin
                    w = noise_word(CMD_LOAD);
                    if ($urandom_range(0, 99) < 88)
                        w.data_last = ($urandom_range(0, 99) < 15);
                    else
                        w.cmd = cmd_t'($urandom_range(1, 3));
                end
                PH_SEND:
                begin
                    w = noise_word(CMD_PULL);
                    if ($urandom_range(0, 99) >= 92)
                    begin
                        c = cmd_t'($urandom_range(0, 2));
                        w.cmd = (c == CMD_PULL) ? CMD_TICK : c;
                    end
                end
                default: w = wait_word(ok_pct, may_fail);
            endcase
            send_word(w);
            if (!last_ignored)
                counted++;
        end
    endtask

    // 512-byte chunk closed by the size limit alone, then sent out completely.
    task automatic long_chunk();
        arq_word_t w;
        while (model.phase != PH_LOAD)
        begin
            if (model.phase == PH_SEND)
                w = noise_word(CMD_PULL);
            else
            begin
                w            = noise_word(CMD_ACK);
                w.ack_length = 7'd3;
                w.ack_type   = ACK_TYPE;
                w.ack_seq    = {7'd0, model.seq_bit};
                w.ack_check  = ACK_TYPE + w.ack_seq;
            end
            send_word(w);
        end
        repeat (CHUNK_MAX)
        begin
            w           = noise_word(CMD_LOAD);
            w.data_last = 1'b0;
            send_word(w);
        end
        while (model.phase == PH_SEND)
            send_word(noise_word(CMD_PULL));
    endtask

    task automatic directed_part();
        send_word(mk(CMD_TICK, 8'h5A, 1'b1, 7'd64, 8'hFF, 8'hFF, 8'hFF));
        send_word(mk(CMD_ACK, 8'h00, 1'b0, 7'd3, ACK_TYPE, 8'd0, 8'd1));
        send_word(mk(CMD_PULL, 8'hA5, 1'b0, 7'd0, 8'h00, 8'h00, 8'h00));
        send_word(mk(CMD_LOAD, 8'h00, 1'b0, 7'd0, 8'h00, 8'h00, 8'h00));
        send_word(mk(CMD_LOAD, 8'hFF, 1'b1, 7'd127, 8'hFF, 8'hFF, 8'hFF));
        send_word(mk(CMD_LOAD, 8'h11, 1'b1, 7'd0, 8'h00, 8'h00, 8'h00));
        repeat (7) send_word(mk(CMD_PULL, 8'h00, 1'b0, 7'd0, 8'h00, 8'h00, 8'h00));
        send_word(mk(CMD_TICK, 8'h00, 1'b0, 7'd0, 8'h00, 8'h00, 8'h00));
        // too short to be an ack: resend
        send_word(mk(CMD_ACK, 8'h00, 1'b0, 7'd2, ACK_TYPE, 8'd0, 8'd1));
        repeat (7) send_word(mk(CMD_PULL, 8'hFF, 1'b1, 7'd64, 8'hFF, 8'hFF, 8'hFF));
        send_word(mk(CMD_ACK, 8'hFF, 1'b1, 7'd64, ACK_TYPE, 8'd0, 8'd1));
    endtask

    // Zero limit and zero timeout: the first tick while waiting ends in the failed phase.
    task automatic fail_sequence();
        arq_word_t w;
        while (model.phase != PH_FAIL)
        begin
            case (model.phase)
                PH_LOAD: w = noise_word(CMD_LOAD);
                PH_SEND: w = noise_word(CMD_PULL);
                default: w = noise_word(CMD_TICK);
            endcase
            send_word(w);
        end
        repeat (12) send_word(noise_word(cmd_t'($urandom_range(0, 3))));
    endtask

    initial
    begin : receiver
        int         ready_hold;
        bit         hold_done;
        tx_result_t got;
        ready_hold = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.tx_valid      = m_tuser;
                got.tx_byte       = m_tdata[7:0];
                got.tx_last       = m_tlast;
                got.phase         = m_tdata[9:8];
                got.chunk_acked   = m_tdata[10];
                got.attempt_count = m_tdata[14:11];
                got.current_seq   = m_tdata[15];
                got.item_ignored  = m_tdata[16];
                model.check_tx(got);
            end
            if (!hold_done && model.results_seen >= 150)
            begin
                hold_done  = 1'b1;
                ready_hold = 300;
            end
            if (ready_hold > 0)
            begin
                ready_hold--;
                m_tready <= 1'b0;
            end
            else if ((model.results_seen / 200) % 4 == 1 || $urandom_range(0, 99) < 75)
                m_tready <= 1'b1;
            else
            begin
                ready_hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                          : $urandom_range(15, 40);
                m_tready <= 1'b0;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_part();
        random_phase(30, 45, 1'b0);

        wait_idle();
        write_reg(REG_ATTEMPT_LIMIT, 16'd15);
        write_reg(REG_TIMEOUT_TICKS, 16'd1);
        random_phase(20, 5, 1'b0);

        wait_idle();
        write_reg(REG_ATTEMPT_LIMIT, 16'd1);
        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
        long_chunk();
        random_phase(15, 50, 1'b0);

        wait_idle();
        write_reg(REG_ATTEMPT_LIMIT, 16'($urandom_range(2, 14)));
        write_reg(REG_TIMEOUT_TICKS, 16'd0);
        random_phase(15, 40, 1'b0);

        wait_idle();
        write_reg(REG_ATTEMPT_LIMIT, 16'($urandom_range(1, 15)));
        write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(1, 6)));
        random_phase(30, 35, 1'b0);

        wait_idle();
        write_reg(REG_ATTEMPT_LIMIT, 16'd0);
        write_reg(REG_TIMEOUT_TICKS, 16'd0);
        fail_sequence();

        wait_idle();
        repeat (8) @(posedge clk);
        if (model.failures == 0 && model.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
